### rtl/amf_pkg.sv
// Package for the ADC channel median filter.
// Holds field widths, register addresses, default parameters and the cell link type.
// No dependencies.
package amf_pkg;

    localparam int SAMPLE_W         = 12;
    localparam int CHANNEL_W        = 3;
    localparam int COUNT_OUT_W      = 5;
    localparam int DEF_MAX_SAMPLES  = 16;
    localparam int DEF_NUM_CHANNELS = 8;

    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] REG_CHANNEL_SELECT = 2'd0;

    typedef struct packed {
        logic                shift;
        logic [SAMPLE_W-1:0] value;
    } amf_link_t;

endpackage

### rtl/amf_cell.sv
// One insertion cell of the sorting row of the median filter.
// Holds one sorted sample and exchanges it with its left neighbor on insertion.
// Depends on amf_pkg.
module amf_cell
    import amf_pkg::*;
(
    input  logic                clk,
    input  logic                ins_en,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                occupied,
    input  logic                at_tail,
    input  amf_link_t           link_in,
    output amf_link_t           link_out,
    output logic [SAMPLE_W-1:0] value
);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic                greater;

    // A cell whose value exceeds the new sample moves one place to the right.
    assign greater = occupied && (value_reg > sample);

    always_comb
    begin
        value_next = value_reg;
        if (ins_en)
        begin
            if (link_in.shift)
            begin
                value_next = link_in.value;
            end
            else if (greater || at_tail)
            begin
                value_next = sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link_out.shift = greater;
    assign link_out.value = value_reg;
    assign value          = value_reg;

endmodule

### rtl/adc_channel_median_filter.sv
// Top level of the ADC channel median filter: APB register, request control,
// the row of insertion cells and the median result register.
// Depends on amf_pkg and amf_cell.
//
// A request without frame_end is accepted while busy is low and leaves busy low,
// so such requests can be issued every cycle. A request with frame_end raises busy
// for the following cycle, in which the median is selected from the cell row;
// the result appears with result_valid in the cycle after that, for one cycle,
// and the receiver cannot stall it. New requests are therefore held off only in
// that median cycle. The store needs no clearing after reset.
module adc_channel_median_filter
    import amf_pkg::*;
#(
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic [CHANNEL_W-1:0]   sample_channel,
    input  logic                   frame_end,
    output logic                   result_valid,
    output logic [SAMPLE_W-1:0]    median_value,
    output logic [COUNT_OUT_W-1:0] sample_count,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    logic [CHANNEL_W-1:0]   channel_select_reg;
    logic [CHANNEL_W-1:0]   channel_select_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   pending_reg;
    logic                   pending_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    logic [SAMPLE_W-1:0]    median_reg;
    logic [SAMPLE_W-1:0]    median_next;
    logic [CNT_W-1:0]       result_count_reg;
    logic [CNT_W-1:0]       result_count_next;

    logic                   accept;
    logic                   match;
    logic                   ins_en;
    logic [IDX_W-1:0]       mid_idx;
    logic [COUNT_OUT_W+CNT_W-1:0] count_wide;

    amf_link_t              links [MAX_SAMPLES+1];
    logic [SAMPLE_W-1:0]    cell_value [MAX_SAMPLES];

    // Configuration port.
    assign pready = 1'b1;

    always_comb
    begin
        channel_select_next = channel_select_reg;
        if (psel && penable && pwrite && (paddr == REG_CHANNEL_SELECT))
        begin
            channel_select_next = pwdata[CHANNEL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_CHANNEL_SELECT)
        begin
            prdata = DATA_W'(channel_select_reg);
        end
    end

    // Request control.
    assign busy   = pending_reg;
    assign accept = start && !busy;
    assign match  = (sample_channel == channel_select_reg)
                 && (32'(sample_channel) < NUM_CHANNELS);
    assign ins_en = accept && match && (count_reg < CNT_W'(MAX_SAMPLES));

    assign mid_idx = IDX_W'((count_reg - CNT_W'(1)) >> 1);

    always_comb
    begin
        count_next        = count_reg;
        pending_next      = 1'b0;
        result_valid_next = 1'b0;
        median_next       = median_reg;
        result_count_next = result_count_reg;
        if (pending_reg)
        begin
            result_valid_next = 1'b1;
            result_count_next = count_reg;
            median_next       = (count_reg == '0) ? '0 : cell_value[mid_idx];
            count_next        = '0;
        end
        else if (accept)
        begin
            pending_next = frame_end;
            if (ins_en)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_select_reg <= '0;
            count_reg          <= '0;
            pending_reg        <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            channel_select_reg <= channel_select_next;
            count_reg          <= count_next;
            pending_reg        <= pending_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg       <= median_next;
        result_count_reg <= result_count_next;
    end

    // Row of insertion cells.
    assign links[0].shift = 1'b0;
    assign links[0].value = '0;

    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        amf_cell u_cell (
            .clk      (clk),
            .ins_en   (ins_en),
            .sample   (sample),
            .occupied (count_reg > CNT_W'(i)),
            .at_tail  (count_reg == CNT_W'(i)),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .value    (cell_value[i])
        );
    end

    // The last link feeds nothing; its shift flag is always ignored.
    assign count_wide   = {COUNT_OUT_W'(0), result_count_reg};
    assign result_valid = result_valid_reg;
    assign median_value = median_reg;
    assign sample_count = count_wide[COUNT_OUT_W-1:0];

`ifndef SYNTHESIS
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid)
        else $error("result did not follow the median cycle");

    a_result_only_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a frame end request");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count exceeds the store depth");
`endif

endmodule

### test/adc_channel_median_filter_test.sv
// Self-checking testbench for adc_channel_median_filter: predicts each frame's lower median
// from the accepted requests and compares every result, with random idling and APB setup.
// Depends on amf_pkg and the adc_channel_median_filter RTL.
class median_predictor;
    typedef struct {
        logic [amf_pkg::SAMPLE_W-1:0]    median;
        logic [amf_pkg::COUNT_OUT_W-1:0] count;
    } median_t;

    logic [amf_pkg::SAMPLE_W-1:0]  sorted_store [amf_pkg::DEF_MAX_SAMPLES];
    int unsigned                   held;
    logic [amf_pkg::CHANNEL_W-1:0] selected;
    median_t                       expected_medians [$];
    int unsigned                   mismatches;
    int unsigned                   requests;
    int unsigned                   frames;
    int unsigned                   full_frames;
    int unsigned                   empty_frames;

    function new();
        held = 0;
        selected = '0;
        mismatches = 0;
        requests = 0;
        frames = 0;
        full_frames = 0;
        empty_frames = 0;
    endfunction

    function void set_channel(logic [31:0] value);
        selected = value[amf_pkg::CHANNEL_W-1:0];
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function void note_request(logic [amf_pkg::SAMPLE_W-1:0] value,
                               logic [amf_pkg::CHANNEL_W-1:0] channel,
                               logic last);
        median_t m;
        int      pos;
        requests++;
        if (channel == selected && int'(channel) < amf_pkg::DEF_NUM_CHANNELS
            && held < amf_pkg::DEF_MAX_SAMPLES)
        begin
            pos = int'(held);
            // Equal values stay ahead of the new sample.
            while (pos > 0 && sorted_store[pos-1] > value)
            begin
                sorted_store[pos] = sorted_store[pos-1];
                pos--;
            end
            sorted_store[pos] = value;
            held++;
        end
        if (last)
        begin
            m.median = (held > 0) ? sorted_store[(held-1)/2] : '0;
            m.count = amf_pkg::COUNT_OUT_W'(held);
            frames++;
            if (held == amf_pkg::DEF_MAX_SAMPLES)
                full_frames++;
            if (held == 0)
                empty_frames++;
            expected_medians.push_back(m);
            held = 0;
        end
    endfunction

    task check_median(logic [amf_pkg::SAMPLE_W-1:0] median,
                      logic [amf_pkg::COUNT_OUT_W-1:0] count);
        median_t m;
        if (expected_medians.size() == 0)
        begin
            report($sformatf("median %0d count %0d with no frame pending", median, count));
            return;
        end
        m = expected_medians.pop_front();
        if (median !== m.median)
            report($sformatf("median_value expected %0d got %0d", m.median, median));
        if (count !== m.count)
            report($sformatf("sample_count expected %0d got %0d", m.count, count));
    endtask
endclass

module adc_channel_median_filter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import amf_pkg::*;

    localparam int          IDLE_LIMIT  = 500;
    localparam int unsigned PHASE_ITEMS = 235;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [SAMPLE_W-1:0]    sample;
    logic [CHANNEL_W-1:0]   sample_channel;
    logic                   frame_end;
    logic                   result_valid;
    logic [SAMPLE_W-1:0]    median_value;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    median_predictor predictor = new();
    bit              quiet;

    adc_channel_median_filter dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample         (sample),
        .sample_channel (sample_channel),
        .frame_end      (frame_end),
        .result_valid   (result_valid),
        .median_value   (median_value),
        .sample_count   (sample_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                predictor.check_median(median_value, sample_count);
            if (start && !busy)
                predictor.note_request(sample, sample_channel, frame_end);
        end
    end

    initial
    begin
        int unsigned stalled;
        stalled = 0;
        while (stalled < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || result_valid || (start && !busy) || (psel && penable && pready))
                stalled = 0;
            else
                stalled++;
        end
        $display("adc_channel_median_filter_test NOT OK");
        $finish;
    end

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_request(logic [SAMPLE_W-1:0] value, logic [CHANNEL_W-1:0] channel,
                                logic last);
        idle_gap();
        start <= 1'b1;
        sample <= value;
        sample_channel <= channel;
        frame_end <= last;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (predictor.expected_medians.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == REG_CHANNEL_SELECT)
            predictor.set_channel(data);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] expected);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== expected)
            predictor.report($sformatf("prdata expected %0d got %0d", expected, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_channel(logic [CHANNEL_W-1:0] channel);
        wait_idle();
        write_reg(REG_CHANNEL_SELECT, DATA_W'(channel));
        read_reg(REG_CHANNEL_SELECT, DATA_W'(channel));
    endtask

    task automatic random_frame(logic [CHANNEL_W-1:0] selected, inout int unsigned items);
        int unsigned          len;
        int unsigned          match_pct;
        int unsigned          style;
        int unsigned          i;
        logic [SAMPLE_W-1:0]  value;
        logic [CHANNEL_W-1:0] channel;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        case ($urandom_range(0, 5))
            0:       match_pct = 0;
            1:       match_pct = 100;
            default: match_pct = 60;
        endcase
        style = $urandom_range(0, 2);
        for (i = 0; i < len; i++)
        begin
            channel = ($urandom_range(0, 99) < match_pct) ? selected
                                                           : CHANNEL_W'($urandom_range(0, 7));
            case (style)
                0:       value = SAMPLE_W'($urandom);
                1:       value = SAMPLE_W'($urandom_range(0, 7));
                default: value = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            endcase
            send_request(value, channel, i == len - 1);
        end
        items += len;
    endtask

    initial
    begin
        logic [CHANNEL_W-1:0] settings [8];
        int unsigned          items;
        int                   i;
        int                   p;
        settings = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        sample_channel = '0;
        frame_end = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_reg(REG_CHANNEL_SELECT, '0);

        // An empty frame, then a short frame with duplicates and a foreign channel.
        send_request(12'hFFF, 3'd7, 1'b1);
        send_request(12'hFFF, 3'd0, 1'b0);
        send_request(12'h000, 3'd0, 1'b0);
        send_request(12'h000, 3'd0, 1'b0);
        send_request(12'd1234, 3'd3, 1'b0);
        send_request(12'd2048, 3'd0, 1'b1);
        // Descending samples overflow the store; the last two are dropped.
        for (i = 0; i < 18; i++)
            send_request(SAMPLE_W'(4095 - 240 * i), 3'd0, i == 17);

        for (p = 0; p < 8; p++)
        begin
            apply_channel(settings[p]);
            quiet = (p == 3);
            items = 0;
            while (items < PHASE_ITEMS)
                random_frame(settings[p], items);
        end
        quiet = 1'b0;
        wait_idle();

        $display("Checked %0d requests in %0d frames across all eight channel settings.",
                 predictor.requests, predictor.frames);
        $display("%0d frames filled the store, %0d were empty, %0d mismatches.",
                 predictor.full_frames, predictor.empty_frames, predictor.mismatches);
        if (predictor.mismatches == 0)
            $display("adc_channel_median_filter_test OK");
        else
            $display("adc_channel_median_filter_test NOT OK");
        $finish;
    end
endmodule

### sim.f
rtl/amf_pkg.sv
rtl/amf_cell.sv
rtl/adc_channel_median_filter.sv
test/adc_channel_median_filter_test.sv
